FILE: rtl/motor_test_step_sequencer_core_defines.svh
// Assertion macros for the sequencer core.
`ifndef MOTOR_TEST_STEP_SEQUENCER_CORE_DEFINES_SVH
`define MOTOR_TEST_STEP_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTSS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mtss assertion failed");

// Next-cycle implication, checked outside reset.
`define MTSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mtss assertion failed");

`endif

FILE: rtl/mtss_pkg.sv
`timescale 1ns / 1ps

package mtss_pkg;

    localparam int MAX_STEP_COUNT = 3;
    localparam int NUM_REGS       = 8;
    localparam int CFG_IDX_W      = 3;

    // Item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TOTAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEHAVIOR_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_WAIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_WAIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_GRACE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEHAVIOR_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_CONFIRM    = 3'd7;

    // Phase codes; terminal phases are PH_TERM_BASE plus the end kind
    localparam logic [3:0] PH_INACTIVE  = 4'd0;
    localparam logic [3:0] PH_PRECHECK  = 4'd1;
    localparam logic [3:0] PH_WAIT_POS  = 4'd2;
    localparam logic [3:0] PH_WAIT_CONF = 4'd3;
    localparam logic [3:0] PH_PULSING   = 4'd4;
    localparam logic [3:0] PH_OFF_CONF  = 4'd5;
    localparam logic [3:0] PH_TERM_BASE = 4'd5;

    // End kinds
    localparam logic [2:0] END_NONE        = 3'd0;
    localparam logic [2:0] END_COMPLETE    = 3'd1;
    localparam logic [2:0] END_REJECTED    = 3'd2;
    localparam logic [2:0] END_INTERRUPTED = 3'd3;
    localparam logic [2:0] END_TIMEOUT     = 3'd4;
    localparam logic [2:0] END_FAULT       = 3'd5;

    // Gate codes
    localparam logic [4:0] GATE_OK         = 5'd0;
    localparam logic [4:0] GATE_BENIGN_LO  = 5'd1;
    localparam logic [4:0] GATE_BENIGN_HI  = 5'd6;
    localparam logic [4:0] GATE_LAST_VALID = 5'd18;

    // Fixed reasons
    localparam logic [5:0] R_NONE               = 6'd0;
    localparam logic [5:0] R_PRECHECK           = 6'd19;
    localparam logic [5:0] R_CANCELED           = 6'd20;
    localparam logic [5:0] R_EMERGENCY          = 6'd21;
    localparam logic [5:0] R_FORBIDDEN          = 6'd22;
    localparam logic [5:0] R_WAIT_POSITION      = 6'd23;
    localparam logic [5:0] R_POSITION_TIMEOUT   = 6'd24;
    localparam logic [5:0] R_POSITION_READY     = 6'd25;
    localparam logic [5:0] R_PULSING            = 6'd26;
    localparam logic [5:0] R_CONFIRM_TIMEOUT    = 6'd27;
    localparam logic [5:0] R_MOTOR_FAULT        = 6'd28;
    localparam logic [5:0] R_SUBMIT_ERROR       = 6'd29;
    localparam logic [5:0] R_OFF_CONFIRM        = 6'd30;
    localparam logic [5:0] R_PULSE_TIMEOUT      = 6'd31;
    localparam logic [5:0] R_COMPLETE           = 6'd32;
    localparam logic [5:0] R_OFF_CONFIRM_FAILED = 6'd33;
    localparam logic [5:0] R_INTERNAL           = 6'd34;

    // Register reset values
    localparam logic [1:0]  RST_STEP_TOTAL     = 2'd1;
    localparam logic        RST_BEHAVIOR_MODE  = 1'b0;
    localparam logic [31:0] RST_POSITION_WAIT  = 32'd60000;
    localparam logic [31:0] RST_CONFIRM_WAIT   = 32'd30000;
    localparam logic [31:0] RST_ACCEPT_GRACE   = 32'd2000;
    localparam logic [31:0] RST_PULSE_LIMIT    = 32'd10000;
    localparam logic [31:0] RST_BEHAVIOR_LIMIT = 32'd25000;
    localparam logic [31:0] RST_OFF_CONFIRM    = 32'd20000;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic        cancel;
        logic        emergency;
        logic        outputs_off;
        logic [4:0]  gate_code;
        logic        confirm_pulse;
        logic        motor_idle;
        logic [15:0] motor_pwm;
        logic        motor_fault;
        logic        submit_error;
    } mtss_in_t;

    typedef struct packed {
        logic       all_off_request;
        logic       pulse_submit;
        logic       finished;
        logic [2:0] end_kind;
        logic [5:0] reason;
        logic [3:0] fsm_now;
        logic [1:0] step_now;
    } mtss_out_t;

    typedef struct packed {
        logic [1:0]  step_total;
        logic        behavior_mode;
        logic [31:0] position_wait_ms;
        logic [31:0] confirm_wait_ms;
        logic [31:0] accept_grace_ms;
        logic [31:0] pulse_limit_ms;
        logic [31:0] behavior_limit_ms;
        logic [31:0] off_confirm_ms;
    } mtss_cfg_t;

    // Map a gate refusal to its reason; unknown codes are internal errors
    function automatic logic [5:0] gate_reason(input logic [4:0] gate);
        return (gate <= GATE_LAST_VALID) ? {1'b0, gate} : R_INTERNAL;
    endfunction

    // Steps in the program; out-of-range totals fall back to one step
    function automatic logic [2:0] steps_in_program(input logic [1:0] total);
        logic [2:0] s;
        s = {1'b0, total};
        return (s >= 3'd1 && s <= 3'(MAX_STEP_COUNT)) ? s : 3'd1;
    endfunction

endpackage

FILE: rtl/mtss_cfg_regs.sv
`timescale 1ns / 1ps

module mtss_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write,
    input  logic [mtss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    output mtss_pkg::mtss_cfg_t                 cfg
);
    import mtss_pkg::*;

    mtss_cfg_t cfg_reg;

    assign cfg = cfg_reg;

    // Decode the index and load the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_total        <= RST_STEP_TOTAL;
            cfg_reg.behavior_mode     <= RST_BEHAVIOR_MODE;
            cfg_reg.position_wait_ms  <= RST_POSITION_WAIT;
            cfg_reg.confirm_wait_ms   <= RST_CONFIRM_WAIT;
            cfg_reg.accept_grace_ms   <= RST_ACCEPT_GRACE;
            cfg_reg.pulse_limit_ms    <= RST_PULSE_LIMIT;
            cfg_reg.behavior_limit_ms <= RST_BEHAVIOR_LIMIT;
            cfg_reg.off_confirm_ms    <= RST_OFF_CONFIRM;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_STEP_TOTAL:     cfg_reg.step_total        <= cfg_data[1:0];
                REG_BEHAVIOR_MODE:  cfg_reg.behavior_mode     <= cfg_data[0];
                REG_POSITION_WAIT:  cfg_reg.position_wait_ms  <= cfg_data;
                REG_CONFIRM_WAIT:   cfg_reg.confirm_wait_ms   <= cfg_data;
                REG_ACCEPT_GRACE:   cfg_reg.accept_grace_ms   <= cfg_data;
                REG_PULSE_LIMIT:    cfg_reg.pulse_limit_ms    <= cfg_data;
                REG_BEHAVIOR_LIMIT: cfg_reg.behavior_limit_ms <= cfg_data;
                REG_OFF_CONFIRM:    cfg_reg.off_confirm_ms    <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: rtl/mtss_seq_fsm.sv
`timescale 1ns / 1ps

module mtss_seq_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  mtss_pkg::mtss_in_t  item,
    input  mtss_pkg::mtss_cfg_t cfg,
    output mtss_pkg::mtss_out_t result
);
    import mtss_pkg::*;

    logic [3:0]  phase_reg,      phase_next;
    logic [1:0]  step_reg,       step_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] pulse_time_reg, pulse_time_next;
    logic        pulse_sent_reg, pulse_sent_next;
    logic        seen_run_reg,   seen_run_next;
    logic [2:0]  end_reg,        end_next;
    logic [5:0]  reason_reg,     reason_next;

    logic        do_finish;
    logic [2:0]  fin_kind;
    logic [5:0]  fin_reason;
    logic        fin_alloff;
    logic        pulse_out;
    logic        benign;
    logic [31:0] step_elapsed;
    logic [31:0] pulse_elapsed;
    logic [31:0] pulse_limit;
    logic        last_step;

    assign benign        = (item.gate_code >= GATE_BENIGN_LO) && (item.gate_code <= GATE_BENIGN_HI);
    assign step_elapsed  = item.now_ms - start_time_reg;
    assign pulse_elapsed = item.now_ms - pulse_time_reg;
    assign pulse_limit   = cfg.behavior_mode ? cfg.behavior_limit_ms : cfg.pulse_limit_ms;
    assign last_step     = ({1'b0, step_reg} + 3'd1) >= steps_in_program(cfg.step_total);

    // Work out the next state for the item in the input register
    always_comb begin
        phase_next      = phase_reg;
        step_next       = step_reg;
        start_time_next = start_time_reg;
        pulse_time_next = pulse_time_reg;
        pulse_sent_next = pulse_sent_reg;
        seen_run_next   = seen_run_reg;
        end_next        = end_reg;
        reason_next     = reason_reg;
        do_finish       = 1'b0;
        fin_kind        = END_NONE;
        fin_reason      = R_NONE;
        fin_alloff      = 1'b0;
        pulse_out       = 1'b0;

        if (item.kind == KIND_START) begin
            // Restart the run from precheck
            phase_next      = PH_PRECHECK;
            step_next       = 2'd0;
            start_time_next = 32'd0;
            pulse_time_next = 32'd0;
            pulse_sent_next = 1'b0;
            seen_run_next   = 1'b0;
            end_next        = END_NONE;
            reason_next     = R_PRECHECK;
        end else if (phase_reg >= PH_PRECHECK && phase_reg <= PH_OFF_CONF) begin
            if (item.cancel) begin
                do_finish  = 1'b1;
                fin_kind   = END_INTERRUPTED;
                fin_reason = R_CANCELED;
                fin_alloff = 1'b1;
            end else if (phase_reg != PH_PRECHECK && item.emergency) begin
                do_finish  = 1'b1;
                fin_kind   = END_INTERRUPTED;
                fin_reason = R_EMERGENCY;
                fin_alloff = 1'b1;
            end else if (phase_reg != PH_PRECHECK && !item.outputs_off) begin
                do_finish  = 1'b1;
                fin_kind   = END_FAULT;
                fin_reason = R_FORBIDDEN;
                fin_alloff = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_PRECHECK: begin
                        if (item.gate_code == GATE_OK) begin
                            phase_next      = PH_WAIT_POS;
                            start_time_next = item.now_ms;
                            reason_next     = R_WAIT_POSITION;
                        end else begin
                            do_finish  = 1'b1;
                            fin_kind   = END_REJECTED;
                            fin_reason = gate_reason(item.gate_code);
                        end
                    end
                    PH_WAIT_POS: begin
                        if (item.gate_code == GATE_OK) begin
                            phase_next      = PH_WAIT_CONF;
                            start_time_next = item.now_ms;
                            reason_next     = R_POSITION_READY;
                        end else if (benign) begin
                            reason_next = {1'b0, item.gate_code};
                            if (step_elapsed > cfg.position_wait_ms) begin
                                do_finish  = 1'b1;
                                fin_kind   = END_TIMEOUT;
                                fin_reason = R_POSITION_TIMEOUT;
                                fin_alloff = 1'b1;
                            end
                        end else begin
                            do_finish  = 1'b1;
                            fin_kind   = END_FAULT;
                            fin_reason = gate_reason(item.gate_code);
                            fin_alloff = 1'b1;
                        end
                    end
                    PH_WAIT_CONF: begin
                        if (benign) begin
                            phase_next      = PH_WAIT_POS;
                            start_time_next = item.now_ms;
                            reason_next     = {1'b0, item.gate_code};
                        end else if (item.gate_code != GATE_OK) begin
                            do_finish  = 1'b1;
                            fin_kind   = END_FAULT;
                            fin_reason = gate_reason(item.gate_code);
                            fin_alloff = 1'b1;
                        end else if (item.confirm_pulse && item.motor_idle && !pulse_sent_reg) begin
                            pulse_out       = 1'b1;
                            pulse_sent_next = 1'b1;
                            pulse_time_next = item.now_ms;
                            phase_next      = PH_PULSING;
                            reason_next     = R_PULSING;
                        end else if (step_elapsed > cfg.confirm_wait_ms) begin
                            do_finish  = 1'b1;
                            fin_kind   = END_TIMEOUT;
                            fin_reason = R_CONFIRM_TIMEOUT;
                            fin_alloff = 1'b1;
                        end
                    end
                    PH_PULSING: begin
                        if (item.motor_fault) begin
                            do_finish  = 1'b1;
                            fin_kind   = END_FAULT;
                            fin_reason = R_MOTOR_FAULT;
                            fin_alloff = 1'b1;
                        end else if (item.submit_error) begin
                            do_finish  = 1'b1;
                            fin_kind   = END_FAULT;
                            fin_reason = R_SUBMIT_ERROR;
                            fin_alloff = 1'b1;
                        end else if (!item.motor_idle) begin
                            seen_run_next = 1'b1;
                        end else if (seen_run_reg) begin
                            phase_next  = PH_OFF_CONF;
                            reason_next = R_OFF_CONFIRM;
                        end else if (pulse_elapsed > cfg.accept_grace_ms) begin
                            do_finish  = 1'b1;
                            fin_kind   = END_FAULT;
                            fin_reason = R_SUBMIT_ERROR;
                            fin_alloff = 1'b1;
                        end else if (pulse_elapsed > pulse_limit) begin
                            do_finish  = 1'b1;
                            fin_kind   = END_FAULT;
                            fin_reason = R_PULSE_TIMEOUT;
                            fin_alloff = 1'b1;
                        end
                    end
                    default: begin
                        // Off confirm
                        if (item.motor_fault) begin
                            do_finish  = 1'b1;
                            fin_kind   = END_FAULT;
                            fin_reason = R_MOTOR_FAULT;
                            fin_alloff = 1'b1;
                        end else if (item.motor_idle && item.motor_pwm == 16'd0) begin
                            if (last_step) begin
                                do_finish  = 1'b1;
                                fin_kind   = END_COMPLETE;
                                fin_reason = R_COMPLETE;
                            end else begin
                                step_next       = step_reg + 2'd1;
                                start_time_next = item.now_ms;
                                pulse_sent_next = 1'b0;
                                seen_run_next   = 1'b0;
                                phase_next      = PH_WAIT_POS;
                                reason_next     = R_WAIT_POSITION;
                            end
                        end else if (pulse_elapsed > cfg.off_confirm_ms) begin
                            do_finish  = 1'b1;
                            fin_kind   = END_FAULT;
                            fin_reason = R_OFF_CONFIRM_FAILED;
                            fin_alloff = 1'b1;
                        end
                    end
                endcase
            end

            // Enter the terminal phase for the end kind
            if (do_finish) begin
                end_next    = fin_kind;
                reason_next = fin_reason;
                phase_next  = PH_TERM_BASE + {1'b0, fin_kind};
            end
        end
    end

    // Build the result from the next state
    always_comb begin
        result.all_off_request = do_finish & fin_alloff;
        result.pulse_submit    = pulse_out;
        result.finished        = do_finish;
        result.end_kind        = end_next;
        result.reason          = reason_next;
        result.fsm_now         = phase_next;
        result.step_now        = step_next;
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_INACTIVE;
            step_reg       <= 2'd0;
            start_time_reg <= 32'd0;
            pulse_time_reg <= 32'd0;
            pulse_sent_reg <= 1'b0;
            seen_run_reg   <= 1'b0;
            end_reg        <= END_NONE;
            reason_reg     <= R_NONE;
        end else if (fire) begin
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            start_time_reg <= start_time_next;
            pulse_time_reg <= pulse_time_next;
            pulse_sent_reg <= pulse_sent_next;
            seen_run_reg   <= seen_run_next;
            end_reg        <= end_next;
            reason_reg     <= reason_next;
        end
    end

endmodule

FILE: rtl/motor_test_step_sequencer_core.sv
`timescale 1ns / 1ps

// Fail-closed motor test step sequencer.
// Input channel s_*: one transaction per start or tick item (valid/ready, s_data).
// Result channel m_*: exactly one result transaction per input transaction, in order.
// Config channel cfg_*: writes register cfg_index with cfg_data; always ready, and
// meant to be written only while no item is in flight.
// Path: an accepted item is held in the input register, is evaluated by the sequencer
// logic and moves into the result register, which drives m_valid, once the result side
// is free.
// Throughput: one item per cycle while results are taken; the only loop is the sequencer
// state, updated in the same cycle the item moves into the result register.
// Reset: the run goes inactive, both registers empty, configuration takes its defaults.
// Stall: while m_ready is low the result holds; one more item can wait in the input
// register, after which s_ready drops until the result is taken.
module motor_test_step_sequencer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  mtss_pkg::mtss_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output mtss_pkg::mtss_out_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mtss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import mtss_pkg::*;

    `include "motor_test_step_sequencer_core_defines.svh"

    logic      in_valid_reg;
    mtss_in_t  in_data_reg;
    logic      out_valid_reg;
    mtss_out_t out_data_reg;
    mtss_cfg_t cfg;
    mtss_out_t result;
    logic      advance;
    logic      fire;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    mtss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mtss_seq_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Hold the accepted transaction until the sequencer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Load the result register, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= result;
        end
    end

    `MTSS_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, fire, m_valid)
    `MTSS_ASSERT_NOW(a_pulse_only_in_pulsing, aclk, aresetn,
        m_valid && m_data.pulse_submit, m_data.fsm_now == PH_PULSING && !m_data.finished)
    `MTSS_ASSERT_NOW(a_finish_phase_matches_kind, aclk, aresetn, m_valid && m_data.finished,
        (m_data.end_kind != END_NONE && m_data.fsm_now == (PH_TERM_BASE + {1'b0, m_data.end_kind})))
    `MTSS_ASSERT_NOW(a_all_off_on_finish, aclk, aresetn,
        m_valid && m_data.all_off_request, m_data.finished)

endmodule

FILE: dv/tb_motor_test_step_sequencer_core.sv
`timescale 1ns / 1ps

module tb_motor_test_step_sequencer_core;

    import mtss_pkg::*;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    mtss_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    mtss_out_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    motor_test_step_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Sequencer mirror: state and register copy
    mtss_cfg_t   seq_cfg;
    logic [3:0]  seq_phase;
    logic [1:0]  seq_step;
    logic [31:0] seq_step_t0;
    logic [31:0] seq_pulse_t0;
    logic        seq_pulsed;
    logic        seq_running;
    logic [2:0]  seq_end_kind;
    logic [5:0]  seq_reason;
    logic        seq_alloff;
    logic        seq_pulse;
    logic        seq_done;

    mtss_in_t    pending[$];
    mtss_out_t   result_due[$];

    int          src_wait;
    int          src_gap_max  = 5;
    int          sink_wait;
    int          sink_gap_max = 5;
    logic [31:0] gen_now      = '0;
    logic [31:0] gen_dt_max   = 32'd40000;
    int          gen_count;
    int          items_sent;
    int          results_seen;
    int          cfg_writes;
    int          pulses_issued;
    int          ends_by_kind[0:7];
    int          mismatch_count;

    // Reset the mirror to its power-on state
    function automatic void seq_reset();
        seq_cfg.step_total        = RST_STEP_TOTAL;
        seq_cfg.behavior_mode     = RST_BEHAVIOR_MODE;
        seq_cfg.position_wait_ms  = RST_POSITION_WAIT;
        seq_cfg.confirm_wait_ms   = RST_CONFIRM_WAIT;
        seq_cfg.accept_grace_ms   = RST_ACCEPT_GRACE;
        seq_cfg.pulse_limit_ms    = RST_PULSE_LIMIT;
        seq_cfg.behavior_limit_ms = RST_BEHAVIOR_LIMIT;
        seq_cfg.off_confirm_ms    = RST_OFF_CONFIRM;
        seq_phase    = PH_INACTIVE;
        seq_step     = '0;
        seq_step_t0  = '0;
        seq_pulse_t0 = '0;
        seq_pulsed   = 1'b0;
        seq_running  = 1'b0;
        seq_end_kind = END_NONE;
        seq_reason   = R_NONE;
    endfunction

    // Enter a terminal phase
    function automatic void seq_end(input logic [2:0] kind, input logic [5:0] why,
                                    input logic alloff);
        seq_done     = 1'b1;
        seq_alloff   = alloff;
        seq_end_kind = kind;
        seq_reason   = why;
        seq_phase    = PH_TERM_BASE + {1'b0, kind};
        ends_by_kind[kind]++;
    endfunction

    // Advance the mirror by one item and return the result it must produce
    function automatic mtss_out_t predict_step_result(input mtss_in_t it);
        mtss_out_t   r;
        logic [31:0] since_step;
        logic [31:0] since_pulse;
        logic [31:0] pulse_cap;
        logic        benign;
        logic [5:0]  refusal;
        logic [2:0]  total;
        seq_alloff  = 1'b0;
        seq_pulse   = 1'b0;
        seq_done    = 1'b0;
        since_step  = it.now_ms - seq_step_t0;
        since_pulse = it.now_ms - seq_pulse_t0;
        benign      = (it.gate_code >= GATE_BENIGN_LO) && (it.gate_code <= GATE_BENIGN_HI);
        refusal     = (it.gate_code > GATE_LAST_VALID) ? R_INTERNAL : {1'b0, it.gate_code};
        pulse_cap   = seq_cfg.behavior_mode ? seq_cfg.behavior_limit_ms
                                            : seq_cfg.pulse_limit_ms;
        total       = (seq_cfg.step_total == 2'd0) ? 3'd1 : {1'b0, seq_cfg.step_total};

        if (it.kind == KIND_START) begin
            seq_phase    = PH_PRECHECK;
            seq_step     = '0;
            seq_step_t0  = '0;
            seq_pulse_t0 = '0;
            seq_pulsed   = 1'b0;
            seq_running  = 1'b0;
            seq_end_kind = END_NONE;
            seq_reason   = R_PRECHECK;
        end else if (seq_phase < PH_PRECHECK || seq_phase > PH_OFF_CONF) begin
            // no run in progress: drop the tick
        end else if (it.cancel) begin
            seq_end(END_INTERRUPTED, R_CANCELED, 1'b1);
        end else if (seq_phase != PH_PRECHECK && it.emergency) begin
            seq_end(END_INTERRUPTED, R_EMERGENCY, 1'b1);
        end else if (seq_phase != PH_PRECHECK && !it.outputs_off) begin
            seq_end(END_FAULT, R_FORBIDDEN, 1'b1);
        end else begin
            case (seq_phase)
                PH_PRECHECK: begin
                    if (it.gate_code == GATE_OK) begin
                        seq_phase   = PH_WAIT_POS;
                        seq_step_t0 = it.now_ms;
                        seq_reason  = R_WAIT_POSITION;
                    end else begin
                        seq_end(END_REJECTED, refusal, 1'b0);
                    end
                end
                PH_WAIT_POS: begin
                    if (it.gate_code == GATE_OK) begin
                        seq_phase   = PH_WAIT_CONF;
                        seq_step_t0 = it.now_ms;
                        seq_reason  = R_POSITION_READY;
                    end else if (benign) begin
                        seq_reason = {1'b0, it.gate_code};
                        if (since_step > seq_cfg.position_wait_ms)
                            seq_end(END_TIMEOUT, R_POSITION_TIMEOUT, 1'b1);
                    end else begin
                        seq_end(END_FAULT, refusal, 1'b1);
                    end
                end
                PH_WAIT_CONF: begin
                    if (benign) begin
                        seq_phase   = PH_WAIT_POS;
                        seq_step_t0 = it.now_ms;
                        seq_reason  = {1'b0, it.gate_code};
                    end else if (it.gate_code != GATE_OK) begin
                        seq_end(END_FAULT, refusal, 1'b1);
                    end else if (it.confirm_pulse && it.motor_idle && !seq_pulsed) begin
                        seq_pulse    = 1'b1;
                        seq_pulsed   = 1'b1;
                        seq_pulse_t0 = it.now_ms;
                        seq_phase    = PH_PULSING;
                        seq_reason   = R_PULSING;
                        pulses_issued++;
                    end else if (since_step > seq_cfg.confirm_wait_ms) begin
                        seq_end(END_TIMEOUT, R_CONFIRM_TIMEOUT, 1'b1);
                    end
                end
                PH_PULSING: begin
                    if (it.motor_fault) begin
                        seq_end(END_FAULT, R_MOTOR_FAULT, 1'b1);
                    end else if (it.submit_error) begin
                        seq_end(END_FAULT, R_SUBMIT_ERROR, 1'b1);
                    end else if (!it.motor_idle) begin
                        seq_running = 1'b1;
                    end else if (seq_running) begin
                        seq_phase  = PH_OFF_CONF;
                        seq_reason = R_OFF_CONFIRM;
                    end else if (since_pulse > seq_cfg.accept_grace_ms) begin
                        seq_end(END_FAULT, R_SUBMIT_ERROR, 1'b1);
                    end else if (since_pulse > pulse_cap) begin
                        seq_end(END_FAULT, R_PULSE_TIMEOUT, 1'b1);
                    end
                end
                default: begin
                    // off confirm: wait for the motor to stop, then next step or done
                    if (it.motor_fault) begin
                        seq_end(END_FAULT, R_MOTOR_FAULT, 1'b1);
                    end else if (it.motor_idle && it.motor_pwm == 16'd0) begin
                        if (({1'b0, seq_step} + 3'd1) >= total) begin
                            seq_end(END_COMPLETE, R_COMPLETE, 1'b0);
                        end else begin
                            seq_step    = seq_step + 2'd1;
                            seq_step_t0 = it.now_ms;
                            seq_pulsed  = 1'b0;
                            seq_running = 1'b0;
                            seq_phase   = PH_WAIT_POS;
                            seq_reason  = R_WAIT_POSITION;
                        end
                    end else if (since_pulse > seq_cfg.off_confirm_ms) begin
                        seq_end(END_FAULT, R_OFF_CONFIRM_FAILED, 1'b1);
                    end
                end
            endcase
        end

        r.all_off_request = seq_alloff;
        r.pulse_submit    = seq_pulse;
        r.finished        = seq_done;
        r.end_kind        = seq_end_kind;
        r.reason          = seq_reason;
        r.fsm_now         = seq_phase;
        r.step_now        = seq_step;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic check_result(input mtss_out_t got);
        mtss_out_t want;
        if (result_due.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", got));
            return;
        end
        want = result_due.pop_front();
        results_seen++;
        check_field("all_off_request", 32'(got.all_off_request), 32'(want.all_off_request));
        check_field("pulse_submit", 32'(got.pulse_submit), 32'(want.pulse_submit));
        check_field("finished", 32'(got.finished), 32'(want.finished));
        check_field("end_kind", 32'(got.end_kind), 32'(want.end_kind));
        check_field("reason", 32'(got.reason), 32'(want.reason));
        check_field("fsm_now", 32'(got.fsm_now), 32'(want.fsm_now));
        check_field("step_now", 32'(got.step_now), 32'(want.step_now));
    endtask

    // Driver: score accepted items, then present the next one after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                result_due.push_back(predict_step_result(s_data));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    src_wait <= src_wait - 1;
                    s_valid  <= 1'b0;
                end else if (pending.size() != 0) begin
                    s_data   <= pending.pop_front();
                    s_valid  <= 1'b1;
                    src_wait <= $urandom_range(0, src_gap_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction, then stall for a drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
                sink_wait = $urandom_range(0, sink_gap_max);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Write one register and mirror it once the transaction completes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_STEP_TOTAL:     seq_cfg.step_total        = val[1:0];
            REG_BEHAVIOR_MODE:  seq_cfg.behavior_mode     = val[0];
            REG_POSITION_WAIT:  seq_cfg.position_wait_ms  = val;
            REG_CONFIRM_WAIT:   seq_cfg.confirm_wait_ms   = val;
            REG_ACCEPT_GRACE:   seq_cfg.accept_grace_ms   = val;
            REG_PULSE_LIMIT:    seq_cfg.pulse_limit_ms    = val;
            REG_BEHAVIOR_LIMIT: seq_cfg.behavior_limit_ms = val;
            default:            seq_cfg.off_confirm_ms    = val;
        endcase
        cfg_writes++;
    endtask

    // Wait until every item is sent and every result is back, then let the pipe settle
    task automatic drain_all();
        do @(negedge aclk); while (pending.size() != 0 || s_valid || result_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    function automatic mtss_in_t fixed_tick(input logic [31:0] now, input logic [4:0] gate);
        mtss_in_t it;
        it             = '0;
        it.kind        = KIND_TICK;
        it.now_ms      = now;
        it.outputs_off = 1'b1;
        it.gate_code   = gate;
        it.motor_idle  = 1'b1;
        return it;
    endfunction

    // Well-behaved tick with the clock advanced by a random step
    function automatic mtss_in_t calm_tick(input logic [4:0] gate);
        mtss_in_t it;
        gen_now = gen_now + ((gen_dt_max == 32'hFFFF_FFFF) ? $urandom
                                                          : $urandom_range(0, gen_dt_max));
        it = fixed_tick(gen_now, gate);
        it.motor_pwm = 16'($urandom);
        return it;
    endfunction

    // Anything at all, mostly ticks
    function automatic mtss_in_t any_item();
        mtss_in_t it;
        it.kind          = ($urandom_range(0, 5) == 0) ? KIND_START : KIND_TICK;
        it.now_ms        = ($urandom_range(0, 3) == 0) ? $urandom
                                                       : gen_now + $urandom_range(0, 16);
        it.cancel        = ($urandom_range(0, 7) == 0);
        it.emergency     = ($urandom_range(0, 7) == 0);
        it.outputs_off   = ($urandom_range(0, 7) != 0);
        it.gate_code     = 5'($urandom_range(0, 31));
        it.confirm_pulse = 1'($urandom);
        it.motor_idle    = 1'($urandom);
        it.motor_pwm     = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
        it.motor_fault   = ($urandom_range(0, 7) == 0);
        it.submit_error  = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // Queue an item, now and then with a safety flag or refusal thrown in
    task automatic post_item(input mtss_in_t it, input logic shake);
        if (shake) begin
            case ($urandom_range(0, 59))
                0: it.cancel = 1'b1;
                1: it.emergency = 1'b1;
                2: it.outputs_off = 1'b0;
                3: it.motor_fault = 1'b1;
                4: it.submit_error = 1'b1;
                5: it.gate_code = 5'($urandom_range(7, 31));
                6: it.gate_code = 5'($urandom_range(GATE_BENIGN_LO, GATE_BENIGN_HI));
                7: begin
                    it.cancel      = 1'b1;
                    it.emergency   = 1'b1;
                    it.outputs_off = 1'b0;
                end
                default: ;
            endcase
        end
        pending.push_back(it);
        gen_count++;
    endtask

    // One run: a start, then either random items or a script that walks every step of the program
    task automatic queue_run();
        mtss_in_t it;
        int       steps;
        int       n;
        it = any_item();
        it.kind = KIND_START;
        post_item(it, 1'b0);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(4, 12)) post_item(any_item(), 1'b0);
            return;
        end
        it = calm_tick(($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : GATE_OK);
        post_item(it, 1'b1);
        steps = (seq_cfg.step_total == 2'd0) ? 1 : seq_cfg.step_total;
        repeat (steps) begin
            // wait position: a few benign refusals, then ready
            n = $urandom_range(0, 3);
            repeat (n) begin
                it = calm_tick(5'($urandom_range(GATE_BENIGN_LO, GATE_BENIGN_HI)));
                it.confirm_pulse = 1'($urandom);
                it.motor_idle    = 1'($urandom);
                it.motor_fault   = 1'($urandom);
                it.submit_error  = 1'($urandom);
                post_item(it, 1'b1);
            end
            post_item(calm_tick(GATE_OK), 1'b1);
            // wait confirm: hold off, then confirm with the motor idle
            n = $urandom_range(0, 2);
            repeat (n) begin
                it = calm_tick(GATE_OK);
                it.confirm_pulse = 1'($urandom);
                it.motor_idle    = it.confirm_pulse ? 1'b0 : 1'($urandom);
                post_item(it, 1'b1);
            end
            it = calm_tick(GATE_OK);
            it.confirm_pulse = 1'b1;
            post_item(it, 1'b1);
            // pulsing: motor runs, then returns to idle
            n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
            repeat (n) begin
                it = calm_tick(GATE_OK);
                it.motor_idle    = 1'b0;
                it.confirm_pulse = 1'($urandom);
                post_item(it, 1'b1);
            end
            post_item(calm_tick(GATE_OK), 1'b1);
            // off confirm: drive still on for a while, then fully off
            n = $urandom_range(0, 2);
            repeat (n) begin
                it = calm_tick(GATE_OK);
                it.motor_idle = 1'($urandom);
                it.motor_pwm  = 16'($urandom_range(1, 65535));
                post_item(it, 1'b1);
            end
            it = calm_tick(GATE_OK);
            it.motor_pwm = 16'd0;
            post_item(it, 1'b1);
        end
    endtask

    task automatic queue_runs(input int count);
        int target;
        target = gen_count + count;
        while (gen_count < target) queue_run();
    endtask

    // Hand-picked items under the reset configuration
    task automatic queue_directed();
        mtss_in_t it;
        // tick with every field at its top while no run is open
        it = fixed_tick(32'hFFFF_FFFF, 5'd31);
        it.cancel        = 1'b1;
        it.emergency     = 1'b1;
        it.confirm_pulse = 1'b1;
        it.motor_pwm     = 16'hFFFF;
        it.motor_fault   = 1'b1;
        it.submit_error  = 1'b1;
        post_item(it, 1'b0);
        it = any_item();
        it.kind = KIND_START;
        post_item(it, 1'b0);
        // emergency and a live output are ignored in precheck
        it = fixed_tick(32'd1000, GATE_OK);
        it.emergency   = 1'b1;
        it.outputs_off = 1'b0;
        post_item(it, 1'b0);
        // position timeout: equal to the limit holds, one past it fires
        post_item(fixed_tick(32'd61000, 5'd3), 1'b0);
        post_item(fixed_tick(32'd61001, 5'd6), 1'b0);
        // tick after a terminal state
        post_item(fixed_tick(32'd70000, GATE_OK), 1'b0);
        it = any_item();
        it.kind = KIND_START;
        post_item(it, 1'b0);
        // clock wraps between step start and position ready
        post_item(fixed_tick(32'hFFFF_FFF0, GATE_OK), 1'b0);
        post_item(fixed_tick(32'd5, GATE_OK), 1'b0);
        post_item(fixed_tick(32'd30005, GATE_OK), 1'b0);
        it = fixed_tick(32'd30006, GATE_OK);
        it.confirm_pulse = 1'b1;
        post_item(it, 1'b0);
        // motor never leaves idle: grace boundary then submit failure
        post_item(fixed_tick(32'd32006, GATE_OK), 1'b0);
        post_item(fixed_tick(32'd32007, GATE_OK), 1'b0);
        // unknown gate code in precheck
        it = any_item();
        it.kind = KIND_START;
        post_item(it, 1'b0);
        post_item(fixed_tick(32'd0, 5'd25), 1'b0);
        // clean single-step run to completion
        it = any_item();
        it.kind = KIND_START;
        post_item(it, 1'b0);
        post_item(fixed_tick(32'd0, GATE_OK), 1'b0);
        post_item(fixed_tick(32'd1, GATE_OK), 1'b0);
        it = fixed_tick(32'd2, GATE_OK);
        it.confirm_pulse = 1'b1;
        post_item(it, 1'b0);
        it = fixed_tick(32'd3, GATE_OK);
        it.motor_idle = 1'b0;
        it.motor_pwm  = 16'hFFFF;
        post_item(it, 1'b0);
        it = fixed_tick(32'd4, GATE_OK);
        it.motor_pwm = 16'd1;
        post_item(it, 1'b0);
        post_item(fixed_tick(32'd5, GATE_OK), 1'b0);
        // restart in the middle of a run, then cancel in precheck
        it = any_item();
        it.kind = KIND_START;
        post_item(it, 1'b0);
        post_item(fixed_tick(32'd6, GATE_OK), 1'b0);
        it = any_item();
        it.kind = KIND_START;
        post_item(it, 1'b0);
        it = fixed_tick(32'd7, GATE_OK);
        it.cancel = 1'b1;
        post_item(it, 1'b0);
    endtask

    // Program all registers for one phase and pick timing and idling
    task automatic set_profile(input int phase_no);
        logic [31:0] lim[0:5];
        logic [31:0] total_w;
        logic [31:0] mode_w;
        int          k;
        case (phase_no % 4)
            0: begin
                for (k = 0; k < 6; k++) lim[k] = 32'd0;
                total_w    = 32'd3;
                mode_w     = 32'd1;
                gen_dt_max = 32'd1;
            end
            1: begin
                for (k = 0; k < 6; k++) lim[k] = $urandom_range(0, 40);
                total_w    = $urandom;
                mode_w     = $urandom;
                gen_dt_max = 32'd12;
            end
            2: begin
                // zero step total in the low bits, junk above
                for (k = 0; k < 6; k++) lim[k] = 32'hFFFF_FFFF;
                total_w    = 32'hFFFF_FFFC;
                mode_w     = 32'hFFFF_FFFE;
                gen_dt_max = 32'hFFFF_FFFF;
            end
            default: begin
                for (k = 0; k < 6; k++) lim[k] = $urandom_range(100, 3000);
                total_w    = 32'd2;
                mode_w     = $urandom;
                gen_dt_max = 32'd600;
            end
        endcase
        write_reg(REG_STEP_TOTAL, total_w);
        write_reg(REG_BEHAVIOR_MODE, mode_w);
        write_reg(REG_POSITION_WAIT, lim[0]);
        write_reg(REG_CONFIRM_WAIT, lim[1]);
        write_reg(REG_ACCEPT_GRACE, lim[2]);
        write_reg(REG_PULSE_LIMIT, lim[3]);
        write_reg(REG_BEHAVIOR_LIMIT, lim[4]);
        write_reg(REG_OFF_CONFIRM, lim[5]);
        gen_now      = (phase_no % 3 == 0) ? 32'hFFFF_FF00 : $urandom;
        src_gap_max  = (phase_no % 3 == 1) ? 16 : ((phase_no % 3 == 2) ? 3 : 0);
        sink_gap_max = (phase_no % 2 == 1) ? 16 : ((phase_no % 4 == 2) ? 0 : 4);
        @(negedge aclk);
    endtask

    // Main sequence: reset, directed items and random runs, then randomized phases
    initial begin
        int phase_no;
        seq_reset();
        queue_directed();
        queue_runs(150);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        drain_all();
        for (phase_no = 1; phase_no <= 9; phase_no++) begin
            set_profile(phase_no);
            queue_runs(180);
            drain_all();
        end
        repeat (10) @(posedge aclk);
        $display("Sent %0d items over 10 register settings (%0d writes), %0d pulses, %0d checked.",
                 items_sent, cfg_writes, pulses_issued, results_seen);
        $display("Run ends: complete %0d rejected %0d interrupted %0d timeout %0d fault %0d.",
                 ends_by_kind[END_COMPLETE], ends_by_kind[END_REJECTED],
                 ends_by_kind[END_INTERRUPTED], ends_by_kind[END_TIMEOUT],
                 ends_by_kind[END_FAULT]);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout with %0d results still expected", result_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mtss_pkg.sv
rtl/mtss_cfg_regs.sv
rtl/mtss_seq_fsm.sv
rtl/motor_test_step_sequencer_core.sv
dv/tb_motor_test_step_sequencer_core.sv
